// ===== design/nbl_pkg.sv =====
`default_nettype none

package nbl_pkg;

    // frame limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    // register width of image_width / image_height
    localparam int SIZE_W = 11;

    // column address into the line stores
    localparam int COL_W = $clog2(MAX_WIDTH);
    // input row runs up to height + 1 while draining
    localparam int IN_ROW_W = $clog2(MAX_HEIGHT + 2);
    // output row stays below height
    localparam int OUT_ROW_W = $clog2(MAX_HEIGHT);

    // neighbor divide by 8 is a right shift
    localparam int NEIGHBOR_SHIFT = 3;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 2);

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

    // input action codes
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    localparam int PIXEL_W = $bits(t_pixel);

    typedef struct packed {
        logic       action;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       frame_end;
    } t_out_item;

endpackage

`default_nettype wire

// ===== design/nbl_ram.sv =====
`default_nettype none

module nbl_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/neighbor_blur_3x3_top.sv =====
`default_nettype none

// channel   direction  handshake                   payload
// in        input      i_in_valid / o_in_stall     i_in_data  (action, red/green/blue)
// out       output     o_out_valid / i_out_stall   o_out_data (red/green/blue, frame_end)
// cfg       input      i_cfg_we                    i_cfg_index, i_cfg_data
//
// one request per clock while o_in_stall is low; a taken pixel goes through the line
// store read, then the window update, whose result is pushed into the result queue
// the first drain request of a one-row frame steps the window twice and holds
// o_in_stall for one extra clock
// o_in_stall also rises when the four-entry result queue could overflow
// i_rst_n is synchronous; counters, window and queue clear, line stores do not

module neighbor_blur_3x3_top (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire nbl_pkg::t_in_item                   i_in_data,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output nbl_pkg::t_out_item                       o_out_data,
    input  wire logic                                i_cfg_we,
    input  wire logic [nbl_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [nbl_pkg::SIZE_W-1:0]          i_cfg_data
);

    import nbl_pkg::*;

    // frame size, already clamped
    logic [SIZE_W-1:0]    r_width;
    logic [SIZE_W-1:0]    r_height;
    logic [SIZE_W-1:0]    w_cfg_eff_w;
    logic [SIZE_W-1:0]    w_cfg_eff_h;

    // positions
    logic [IN_ROW_W-1:0]  r_in_row;
    logic [COL_W-1:0]     r_in_col;
    logic [OUT_ROW_W-1:0] r_out_row;
    logic [COL_W-1:0]     r_out_col;

    // second window step of a one-row frame
    logic                 r_extra;

    // issue side
    logic                 w_accept;
    logic                 w_draining;
    logic                 w_issue;
    logic                 w_due;
    logic                 w_border;
    logic                 w_last;
    logic                 w_col_wrap;
    t_pixel               w_issue_px;
    logic [SIZE_W-1:0]    w_col_inc;
    logic [SIZE_W-1:0]    w_out_row_inc;
    logic [SIZE_W-1:0]    w_out_col_inc;

    // window stage
    logic                 r_b_valid;
    logic                 r_b_due;
    logic                 r_b_border;
    logic                 r_b_last;
    logic [COL_W-1:0]     r_b_addr;
    t_pixel               r_b_px;

    // forwarding around a same-address line store write
    logic                 r_fwd;
    t_pixel               r_fwd_up;
    t_pixel               r_fwd_mid;

    logic [PIXEL_W-1:0]   w_ram_up_q;
    logic [PIXEL_W-1:0]   w_ram_mid_q;
    t_pixel               w_up_q;
    t_pixel               w_mid_q;

    t_pixel               r_win [3][3];
    t_pixel               n_win [3][3];
    t_out_item            w_result;
    logic [7:0]           w_sum_r;
    logic [7:0]           w_sum_g;
    logic [7:0]           w_sum_b;

    // result queue
    t_out_item            r_fifo [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic                 w_push;
    logic                 w_pop;

    // ---------------------------------------------------------------
    // size clamp: 0 counts as 1, anything above the maximum as the maximum
    // ---------------------------------------------------------------
    always_comb begin
        priority if (i_cfg_data == '0) begin
            w_cfg_eff_w = SIZE_W'(1);
        end else if (i_cfg_data > SIZE_W'(MAX_WIDTH)) begin
            w_cfg_eff_w = SIZE_W'(MAX_WIDTH);
        end else begin
            w_cfg_eff_w = i_cfg_data;
        end
        priority if (i_cfg_data == '0) begin
            w_cfg_eff_h = SIZE_W'(1);
        end else if (i_cfg_data > SIZE_W'(MAX_HEIGHT)) begin
            w_cfg_eff_h = SIZE_W'(MAX_HEIGHT);
        end else begin
            w_cfg_eff_h = i_cfg_data;
        end
    end

    // ---------------------------------------------------------------
    // input side: decide on a window step and its output position
    // ---------------------------------------------------------------
    // a new request could land one more result in the queue on top of the
    // one in the window stage
    assign o_in_stall = r_extra ||
        ((r_count + FIFO_CNT_W'(r_b_valid && r_b_due)) > FIFO_CNT_W'(FIFO_DEPTH - 1));

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_draining = SIZE_W'(r_in_row) >= r_height;

    // a drain request before the frame is complete does nothing
    assign w_issue = (w_accept && (w_draining || i_in_data.action == ACT_PIXEL)) || r_extra;

    always_comb begin
        if (w_draining || r_extra) begin
            w_issue_px = '0;
        end else begin
            w_issue_px = '{red: i_in_data.red_in, green: i_in_data.green_in,
                           blue: i_in_data.blue_in};
        end
    end

    // outputs trail the input by one row plus one pixel
    assign w_due = (r_in_row >= IN_ROW_W'(2)) ||
                   (r_in_row == IN_ROW_W'(1) && r_in_col != '0);

    assign w_out_row_inc = SIZE_W'(r_out_row) + SIZE_W'(1);
    assign w_out_col_inc = SIZE_W'(r_out_col) + SIZE_W'(1);
    assign w_col_inc     = SIZE_W'(r_in_col) + SIZE_W'(1);
    assign w_col_wrap    = w_col_inc >= r_width;

    assign w_border = (r_out_row == '0) || (w_out_row_inc >= r_height) ||
                      (r_out_col == '0) || (w_out_col_inc >= r_width);
    assign w_last   = (w_out_row_inc >= r_height) && (w_out_col_inc >= r_width);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= SIZE_W'(MAX_WIDTH);
            r_height  <= SIZE_W'(MAX_HEIGHT);
            r_in_row  <= '0;
            r_in_col  <= '0;
            r_out_row <= '0;
            r_out_col <= '0;
            r_extra   <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= w_issue;
            // a one-row frame's first drain step produces nothing; step again
            r_extra   <= w_issue && !r_extra && w_draining && !w_due;
            if (i_cfg_we) begin
                // a size write abandons the frame in progress
                unique case (i_cfg_index)
                    CFG_IMAGE_WIDTH:  r_width  <= w_cfg_eff_w;
                    CFG_IMAGE_HEIGHT: r_height <= w_cfg_eff_h;
                    default: ;
                endcase
                r_in_row  <= '0;
                r_in_col  <= '0;
                r_out_row <= '0;
                r_out_col <= '0;
            end else if (w_issue) begin
                if (w_due && w_last) begin
                    // frame done, next pixel starts a new one
                    r_in_row  <= '0;
                    r_in_col  <= '0;
                    r_out_row <= '0;
                    r_out_col <= '0;
                end else begin
                    if (w_col_wrap) begin
                        r_in_col <= '0;
                        r_in_row <= r_in_row + IN_ROW_W'(1);
                    end else begin
                        r_in_col <= COL_W'(w_col_inc);
                    end
                    if (w_due) begin
                        if (w_out_col_inc >= r_width) begin
                            r_out_col <= '0;
                            r_out_row <= OUT_ROW_W'(w_out_row_inc);
                        end else begin
                            r_out_col <= COL_W'(w_out_col_inc);
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_b_due    <= w_due;
            r_b_border <= w_border;
            r_b_last   <= w_last;
            r_b_addr   <= r_in_col;
            r_b_px     <= w_issue_px;
        end
    end

    // ---------------------------------------------------------------
    // line stores: read at issue, written back from the window stage registers later
    // ---------------------------------------------------------------
    nbl_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (MAX_WIDTH)
    ) u_upper_line (
        .i_clk   (i_clk),
        .i_we    (r_b_valid),
        .i_waddr (r_b_addr),
        .i_wdata (w_mid_q),
        .i_re    (w_issue),
        .i_raddr (r_in_col),
        .o_rdata (w_ram_up_q)
    );

    nbl_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (MAX_WIDTH)
    ) u_middle_line (
        .i_clk   (i_clk),
        .i_we    (r_b_valid),
        .i_waddr (r_b_addr),
        .i_wdata (r_b_px),
        .i_re    (w_issue),
        .i_raddr (r_in_col),
        .o_rdata (w_ram_mid_q)
    );

    // a read that met the write of the same column returned stale data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else begin
            r_fwd <= r_b_valid && w_issue && (r_b_addr == r_in_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            r_fwd_up  <= w_mid_q;
            r_fwd_mid <= r_b_px;
        end
    end

    assign w_up_q  = r_fwd ? r_fwd_up  : t_pixel'(w_ram_up_q);
    assign w_mid_q = r_fwd ? r_fwd_mid : t_pixel'(w_ram_mid_q);

    // ---------------------------------------------------------------
    // window shift and blur
    // ---------------------------------------------------------------
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_win[r][0] = r_win[r][1];
            n_win[r][1] = r_win[r][2];
        end
        n_win[0][2] = w_up_q;
        n_win[1][2] = w_mid_q;
        n_win[2][2] = r_b_px;
    end

    // each neighbor is shifted before the add, so the sum never passes 248
    always_comb begin
        w_sum_r = '0;
        w_sum_g = '0;
        w_sum_b = '0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (!(r == 1 && c == 1)) begin
                    w_sum_r = w_sum_r + (n_win[r][c].red   >> NEIGHBOR_SHIFT);
                    w_sum_g = w_sum_g + (n_win[r][c].green >> NEIGHBOR_SHIFT);
                    w_sum_b = w_sum_b + (n_win[r][c].blue  >> NEIGHBOR_SHIFT);
                end
            end
        end
    end

    always_comb begin
        if (r_b_border) begin
            // border pixels pass through untouched
            w_result.red_out   = n_win[1][1].red;
            w_result.green_out = n_win[1][1].green;
            w_result.blue_out  = n_win[1][1].blue;
        end else begin
            w_result.red_out   = w_sum_r;
            w_result.green_out = w_sum_g;
            w_result.blue_out  = w_sum_b;
        end
        w_result.frame_end = r_b_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= '0;
                end
            end
        end else if (r_b_valid) begin
            r_win <= n_win;
        end
    end

    // ---------------------------------------------------------------
    // result queue: decouples the window stage from output stalls
    // ---------------------------------------------------------------
    assign w_push = r_b_valid && r_b_due;
    assign w_pop  = o_out_valid && !i_out_stall;

    assign o_out_valid = r_count != '0;
    assign o_out_data  = r_fifo[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(1);
            end
            r_count <= r_count + FIFO_CNT_W'(w_push) - FIFO_CNT_W'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo[r_wr_ptr] <= w_result;
        end
    end

endmodule

`default_nettype wire
